### design/wtra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtra_pkg;

   localparam int REG_COUNT_DEF = 64;

   localparam int CMD_W   = 9;
   localparam int VAL_W   = 32;
   localparam int RIDX_W  = 6;
   localparam int WID_W   = 6;
   localparam int STAT_W  = 3;
   localparam int ADV_W   = 3;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 40;

   localparam logic [CMD_W-1:0] OP_NOP   = 9'h000;
   localparam logic [CMD_W-1:0] OP_LIMM  = 9'h002;
   localparam logic [CMD_W-1:0] OP_OR    = 9'h010;
   localparam logic [CMD_W-1:0] OP_XOR   = 9'h011;
   localparam logic [CMD_W-1:0] OP_AND   = 9'h012;
   localparam logic [CMD_W-1:0] OP_ADD   = 9'h014;
   localparam logic [CMD_W-1:0] OP_SUB   = 9'h015;
   localparam logic [CMD_W-1:0] OP_MUL   = 9'h016;
   localparam logic [CMD_W-1:0] OP_ABORT = 9'h1FF;

   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADW    = 3'd2;
   localparam logic [STAT_W-1:0] ST_ABORT   = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

   localparam logic [ADV_W-1:0] ADV_NONE = 3'd0;
   localparam logic [ADV_W-1:0] ADV_NOP  = 3'd1;
   localparam logic [ADV_W-1:0] ADV_LIMM = 3'd4;
   localparam logic [ADV_W-1:0] ADV_ALU  = 3'd5;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADV_W-1:0]  advance;
      logic [VAL_W-1:0]  written_value;
      logic              wrote;
   } rsp_type;

endpackage

`default_nettype wire

### design/width_tagged_register_alu_step_core.sv
// An accepted request word is registered into the execute stage; its result is then registered into the response word.
// Throughput: one word per cycle while the response side keeps up; a new request is taken while a result waits.
// The register file is a two-read, one-write memory read at acceptance and
// written back as the word leaves the execute stage, with a bypass for back-to-back dependencies.
// Reset clears per-entry valid bits at once, so every register reads as zero.
`timescale 1ns / 1ps
`default_nettype none

module width_tagged_register_alu_step_core
   import wtra_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   // Fields from bit 0: cmd, immediate, dest_reg, src_a_reg, src_b_reg, width, zero fill.
   input  wire  [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   // Fields from bit 0: status, advance, written_value, wrote, zero fill.
   output logic [RSP_W-1:0]   rsp_tdata
);

   localparam int IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int RAW_N  = 2 ** RIDX_W;
   localparam int ENT_W  = VAL_W + WID_W;

   logic [IDX_W-1:0]  idx_lut [RAW_N];
   logic [ENT_W-1:0]  reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;

   genvar g;
   generate
      for (g = 0; g < RAW_N; g++) begin : g_lut
         assign idx_lut[g] = IDX_W'(g % REG_COUNT);
      end
   endgenerate

   logic [CMD_W-1:0]  in_cmd;
   logic [VAL_W-1:0]  in_imm;
   logic [IDX_W-1:0]  in_rd, in_ra, in_rb;
   logic [WID_W-1:0]  in_w;

   assign in_cmd = req_tdata[8:0];
   assign in_imm = req_tdata[40:9];
   assign in_rd  = idx_lut[req_tdata[46:41]];
   assign in_ra  = idx_lut[req_tdata[52:47]];
   assign in_rb  = idx_lut[req_tdata[58:53]];
   assign in_w   = req_tdata[64:59];

   logic              s1_vld_ff, s1_vld_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [VAL_W-1:0]  s1_imm_ff;
   logic [IDX_W-1:0]  s1_rd_ff;
   logic [WID_W-1:0]  s1_w_ff;
   logic [ENT_W-1:0]  rd_a_ff, rd_b_ff;
   logic              rv_a_ff, rv_b_ff;
   logic              byp_a_ff, byp_b_ff;
   logic [ENT_W-1:0]  byp_ent_ff;

   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff;

   logic              s1_go, accept;
   logic              wr_en;
   logic [ENT_W-1:0]  wr_ent;
   rsp_type           s1_rsp;

   assign s1_go      = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_go;
   assign accept     = req_tvalid && req_tready;
   assign s1_vld_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);
   assign out_vld_in = s1_go ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   logic [VAL_W-1:0]  a_val, b_val;
   logic [WID_W-1:0]  a_wid, b_wid;
   logic [2*VAL_W-1:0] prod;
   logic signed [VAL_W-1:0] imm_sh;
   logic              fits;
   logic [VAL_W-1:0]  alu_res;
   logic              is_alu;

   always_comb begin
      a_val = byp_a_ff ? byp_ent_ff[VAL_W-1:0] : (rv_a_ff ? rd_a_ff[VAL_W-1:0] : '0);
      a_wid = byp_a_ff ? byp_ent_ff[ENT_W-1:VAL_W] : (rv_a_ff ? rd_a_ff[ENT_W-1:VAL_W] : '0);
      b_val = byp_b_ff ? byp_ent_ff[VAL_W-1:0] : (rv_b_ff ? rd_b_ff[VAL_W-1:0] : '0);
      b_wid = byp_b_ff ? byp_ent_ff[ENT_W-1:VAL_W] : (rv_b_ff ? rd_b_ff[ENT_W-1:VAL_W] : '0);
   end

   assign prod   = a_val * b_val;
   assign imm_sh = $signed(s1_imm_ff) >>> (s1_w_ff[4:0] - 5'd1);

   always_comb begin
      if (s1_w_ff == '0) begin
         fits = 1'b0;
      end else if (s1_w_ff >= WID_W'(VAL_W)) begin
         fits = 1'b1;
      end else begin
         fits = (&imm_sh) || !(|imm_sh);
      end
   end

   always_comb begin
      is_alu  = 1'b1;
      alu_res = '0;
      unique case (s1_cmd_ff)
         OP_OR:   alu_res = a_val | b_val;
         OP_XOR:  alu_res = a_val ^ b_val;
         OP_AND:  alu_res = a_val & b_val;
         OP_ADD:  alu_res = a_val + b_val;
         OP_SUB:  alu_res = a_val - b_val;
         OP_MUL:  alu_res = prod[VAL_W-1:0];
         default: is_alu  = 1'b0;
      endcase
   end

   always_comb begin
      s1_rsp = '{status: ST_OK, advance: ADV_NONE, written_value: '0, wrote: 1'b0};
      wr_ent = {s1_w_ff, s1_imm_ff};
      if (is_alu) begin
         if (s1_w_ff > a_wid || s1_w_ff > b_wid) begin
            s1_rsp.status = ST_BADW;
         end else begin
            s1_rsp.advance       = ADV_ALU;
            s1_rsp.written_value = alu_res;
            s1_rsp.wrote         = 1'b1;
            wr_ent               = {s1_w_ff, alu_res};
         end
      end else begin
         unique case (s1_cmd_ff)
            OP_NOP: begin
               s1_rsp.advance = ADV_NOP;
            end
            OP_LIMM: begin
               s1_rsp.status        = fits ? ST_OK : ST_RANGE;
               s1_rsp.advance       = ADV_LIMM;
               s1_rsp.written_value = s1_imm_ff;
               s1_rsp.wrote         = 1'b1;
            end
            OP_ABORT: begin
               s1_rsp.status = ST_ABORT;
            end
            default: begin
               s1_rsp.status = ST_UNKNOWN;
            end
         endcase
      end
   end

   assign wr_en = s1_go && s1_rsp.wrote;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[s1_rd_ff] <= wr_ent;
      end
      if (accept) begin
         rd_a_ff <= reg_mem[in_ra];
         rd_b_ff <= reg_mem[in_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[s1_rd_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= in_cmd;
         s1_imm_ff  <= in_imm;
         s1_rd_ff   <= in_rd;
         s1_w_ff    <= in_w;
         rv_a_ff    <= vld_ff[in_ra];
         rv_b_ff    <= vld_ff[in_rb];
         byp_a_ff   <= wr_en && (s1_rd_ff == in_ra);
         byp_b_ff   <= wr_en && (s1_rd_ff == in_rb);
         byp_ent_ff <= wr_ent;
      end
      if (s1_go) begin
         out_ff <= s1_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.wrote, out_ff.written_value, out_ff.advance,
                        out_ff.status};

   a_wrote_status: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.wrote |-> out_ff.status == ST_OK || out_ff.status == ST_RANGE)
      else $error("A written register carries an error status.");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.wrote |-> out_ff.written_value == '0)
      else $error("A word without a write carries a non-zero value.");

   a_adv_status: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff.advance == ADV_NONE) ==
         (out_ff.status == ST_BADW || out_ff.status == ST_ABORT ||
          out_ff.status == ST_UNKNOWN))
      else $error("Advance disagrees with the status.");

   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(s1_rd_ff)])
      else $error("A written register was not marked valid.");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_tready)
      else $error("The block refuses a word with an empty execute stage.");

endmodule

`default_nettype wire

### dv/wtra_step_checker.sv
`timescale 1ns / 1ps

module wtra_step_checker
   import wtra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               failures,
   output int               pending
);

   logic [VAL_W-1:0] reg_value_copy [REG_COUNT_DEF];
   logic [WID_W-1:0] reg_width_copy [REG_COUNT_DEF];
   rsp_type          expected_words [$];

   function automatic bit fits_width(logic [VAL_W-1:0] v, int unsigned w);
      longint sv;
      longint lim;
      if (w == 0) return 1'b0;
      if (w >= 32) return 1'b1;
      sv  = longint'($signed(v));
      lim = longint'(1) << (w - 1);
      return (sv >= -lim) && (sv <= lim - 1);
   endfunction

   function automatic rsp_type execute_word(logic [REQ_W-1:0] word);
      logic [CMD_W-1:0] cmd;
      logic [VAL_W-1:0] imm;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
      logic [VAL_W-1:0] r;
      logic [WID_W-1:0] wid;
      int               rd;
      int               ra;
      int               rb;
      rsp_type          res;
      cmd = word[8:0];
      imm = word[40:9];
      rd  = int'(word[46:41]) % REG_COUNT_DEF;
      ra  = int'(word[52:47]) % REG_COUNT_DEF;
      rb  = int'(word[58:53]) % REG_COUNT_DEF;
      wid = word[64:59];
      res = '0;
      res.status  = ST_OK;
      res.advance = ADV_NONE;
      case (cmd)
         OP_NOP: begin
            res.advance = ADV_NOP;
         end
         OP_LIMM: begin
            reg_value_copy[rd] = imm;
            reg_width_copy[rd] = wid;
            if (!fits_width(imm, wid)) res.status = ST_RANGE;
            res.advance       = ADV_LIMM;
            res.written_value = imm;
            res.wrote         = 1'b1;
         end
         OP_OR, OP_XOR, OP_AND, OP_ADD, OP_SUB, OP_MUL: begin
            if (wid > reg_width_copy[ra] || wid > reg_width_copy[rb]) begin
               res.status = ST_BADW;
            end else begin
               a = reg_value_copy[ra];
               b = reg_value_copy[rb];
               case (cmd)
                  OP_OR:   r = a | b;
                  OP_XOR:  r = a ^ b;
                  OP_AND:  r = a & b;
                  OP_ADD:  r = a + b;
                  OP_SUB:  r = a - b;
                  default: r = a * b;
               endcase
               reg_value_copy[rd] = r;
               reg_width_copy[rd] = wid;
               res.advance       = ADV_ALU;
               res.written_value = r;
               res.wrote         = 1'b1;
            end
         end
         OP_ABORT: begin
            res.status = ST_ABORT;
         end
         default: begin
            res.status = ST_UNKNOWN;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT_DEF; i++) begin
            reg_value_copy[i] = '0;
            reg_width_copy[i] = '0;
         end
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status        = rsp_tdata[2:0];
            seen.advance       = rsp_tdata[5:3];
            seen.written_value = rsp_tdata[37:6];
            seen.wrote         = rsp_tdata[38];
            if (expected_words.size() == 0) begin
               $error("response word with no request outstanding: %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_words.pop_front();
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, seen.status);
                  failures++;
               end
               if (seen.advance !== want.advance) begin
                  $error("advance: expected %0d, got %0d", want.advance, seen.advance);
                  failures++;
               end
               if (seen.written_value !== want.written_value) begin
                  $error("written_value: expected %h, got %h",
                         want.written_value, seen.written_value);
                  failures++;
               end
               if (seen.wrote !== want.wrote) begin
                  $error("wrote: expected %0d, got %0d", want.wrote, seen.wrote);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) expected_words.push_back(execute_word(req_tdata));
      end
      pending = expected_words.size();
   end

endmodule

### dv/width_tagged_register_alu_step_core_tb.sv
`timescale 1ns / 1ps

module width_tagged_register_alu_step_core_tb;
   import wtra_pkg::*;

   localparam logic [CMD_W-1:0] OP_UNUSED  = 9'h013;
   localparam logic [CMD_W-1:0] OP_HIGHEST = 9'h0FF;
   localparam int               RANDOM_WORDS = 1250;
   localparam int               HOLD_CYCLES  = 300;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // Fields from bit 0: cmd, immediate, dest_reg, src_a_reg, src_b_reg, width, zero fill.
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // Fields from bit 0: status, advance, written_value, wrote, zero fill.
   logic [RSP_W-1:0] rsp_tdata;

   int failures;
   int pending;
   int words_sent = 0;
   bit req_calm   = 1'b0;
   bit rsp_calm   = 1'b0;
   bit hold_done  = 1'b0;

   width_tagged_register_alu_step_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wtra_step_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap(bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [RIDX_W-1:0] pick_reg();
      if ($urandom_range(0, 3) != 0) return RIDX_W'($urandom_range(0, 7));
      return RIDX_W'($urandom_range(0, 63));
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] imm,
                            input logic [RIDX_W-1:0] rd, input logic [RIDX_W-1:0] ra,
                            input logic [RIDX_W-1:0] rb, input logic [WID_W-1:0] wid);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, wid, rb, ra, rd, imm, cmd};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
   endtask

   task automatic send_random();
      int                      roll;
      int                      wid;
      logic [CMD_W-1:0]        cmd;
      logic signed [VAL_W-1:0] imm;
      roll = $urandom_range(0, 99);
      imm  = $urandom;
      wid  = 0;
      if (roll < 40) begin
         cmd  = OP_LIMM;
         roll = $urandom_range(0, 19);
         if (roll < 12) wid = $urandom_range(16, 32);
         else if (roll < 17) wid = $urandom_range(1, 15);
         else if (roll == 17) wid = 0;
         else wid = $urandom_range(33, 63);
         if (wid >= 1 && wid <= 31) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) imm = imm >>> (32 - wid);
            else if (roll == 6) imm = 32'sd1 <<< (wid - 1);
            else if (roll == 7) imm = -(32'sd1 <<< (wid - 1)) - 32'sd1;
            else if (roll == 8) imm = (32'sd1 <<< (wid - 1)) - 32'sd1;
         end
      end else if (roll < 88) begin
         case ($urandom_range(0, 5))
            0:       cmd = OP_OR;
            1:       cmd = OP_XOR;
            2:       cmd = OP_AND;
            3:       cmd = OP_ADD;
            4:       cmd = OP_SUB;
            default: cmd = OP_MUL;
         endcase
         roll = $urandom_range(0, 9);
         if (roll < 7) wid = $urandom_range(0, 16);
         else if (roll < 9) wid = $urandom_range(17, 32);
         else wid = $urandom_range(33, 63);
      end else if (roll < 93) begin
         cmd = OP_NOP;
      end else if (roll < 95) begin
         cmd = OP_ABORT;
      end else begin
         do cmd = CMD_W'($urandom_range(0, 255));
         while (cmd == OP_NOP || cmd == OP_LIMM || cmd == OP_OR || cmd == OP_XOR ||
                cmd == OP_AND || cmd == OP_ADD || cmd == OP_SUB || cmd == OP_MUL);
         wid = $urandom_range(0, 63);
      end
      send_word(cmd, imm, pick_reg(), pick_reg(), pick_reg(), wid[WID_W-1:0]);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_word(OP_NOP,     32'h0,        6'd0,  6'd0,  6'd0,  6'd0);
      send_word(OP_ABORT,   32'h0,        6'd1,  6'd2,  6'd3,  6'd4);
      send_word(OP_UNUSED,  32'h1234,     6'd9,  6'd10, 6'd11, 6'd5);
      send_word(OP_HIGHEST, 32'hFFFFFFFF, 6'd63, 6'd63, 6'd63, 6'd63);
      send_word(OP_ADD,     32'h0,        6'd9,  6'd10, 6'd11, 6'd0);
      send_word(OP_ADD,     32'h0,        6'd9,  6'd10, 6'd11, 6'd1);
      send_word(OP_LIMM,    32'h0,        6'd0,  6'd0,  6'd0,  6'd0);
      send_word(OP_LIMM,    32'h7FFFFFFF, 6'd1,  6'd0,  6'd0,  6'd32);
      send_word(OP_LIMM,    32'h80000000, 6'd2,  6'd0,  6'd0,  6'd32);
      send_word(OP_LIMM,    32'd127,      6'd3,  6'd0,  6'd0,  6'd8);
      send_word(OP_LIMM,    32'd128,      6'd4,  6'd0,  6'd0,  6'd8);
      send_word(OP_LIMM,    -32'sd128,    6'd5,  6'd0,  6'd0,  6'd8);
      send_word(OP_LIMM,    -32'sd129,    6'd6,  6'd0,  6'd0,  6'd8);
      send_word(OP_LIMM,    32'hFFFFFFFF, 6'd7,  6'd0,  6'd0,  6'd1);
      send_word(OP_LIMM,    32'hDEADBEEF, 6'd63, 6'd0,  6'd0,  6'd63);
      send_word(OP_OR,      32'h0,        6'd8,  6'd1,  6'd2,  6'd32);
      send_word(OP_XOR,     32'h0,        6'd8,  6'd1,  6'd5,  6'd8);
      send_word(OP_AND,     32'h0,        6'd8,  6'd3,  6'd5,  6'd8);
      send_word(OP_ADD,     32'h0,        6'd8,  6'd1,  6'd1,  6'd32);
      send_word(OP_SUB,     32'h0,        6'd8,  6'd2,  6'd1,  6'd32);
      send_word(OP_MUL,     32'h0,        6'd8,  6'd63, 6'd63, 6'd33);
      send_word(OP_SUB,     32'h0,        6'd3,  6'd3,  6'd5,  6'd8);
      send_word(OP_ADD,     32'h0,        6'd4,  6'd4,  6'd6,  6'd9);
      send_word(OP_NOP,     32'hFFFFFFFF, 6'd63, 6'd63, 6'd63, 6'd63);
      repeat (RANDOM_WORDS) send_random();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("width_tagged_register_alu_step_core_tb OK");
      end else begin
         $display("width_tagged_register_alu_step_core_tb NOT OK");
      end
      $finish;
   end

   // One long hold-off on the result side lets the block fill up and push back on requests.
   initial begin
      int lo;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!hold_done && words_sent >= 200) begin
            hold_done = 1'b1;
            lo = HOLD_CYCLES;
         end else begin
            lo = pick_gap(rsp_calm);
         end
         if (lo > 0) begin
            rsp_tready <= 1'b0;
            repeat (lo) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
      end
   end

   initial begin
      #2000000;
      $display("width_tagged_register_alu_step_core_tb NOT OK");
      $finish;
   end

endmodule

### width_tagged_register_alu_step_core.f
design/wtra_pkg.sv
design/width_tagged_register_alu_step_core.sv
dv/wtra_step_checker.sv
dv/width_tagged_register_alu_step_core_tb.sv
